FILE: hdl/v3n_pkg.sv
// v3n_pkg: types and constants for the vector3_normalize_core pipeline.
// No dependencies.
package v3n_pkg;

   localparam int unsigned CompWidth  = 16;
   localparam int unsigned SumWidth   = 32;
   localparam int unsigned RootWidth  = 16;
   localparam int unsigned QuoWidth   = 15;
   localparam int unsigned FracBits   = 14;
   localparam int unsigned Lanes      = 3;
   localparam logic [QuoWidth-1:0] QOne = 15'd16384;

   typedef struct packed {
      logic signed [CompWidth-1:0] vec_x;
      logic signed [CompWidth-1:0] vec_y;
      logic signed [CompWidth-1:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [CompWidth-1:0] unit_x;
      logic signed [CompWidth-1:0] unit_y;
      logic signed [CompWidth-1:0] unit_z;
   } rsp_type;

   // state handed along the square-root chain
   typedef struct packed {
      logic [SumWidth-1:0]              n;
      logic [RootWidth+1:0]             rem;
      logic [RootWidth-1:0]             root;
      logic [Lanes-1:0][CompWidth-1:0]  mag;
      logic [Lanes-1:0]                 neg;
   } sq_stage_type;

   // state handed along the divider chain
   typedef struct packed {
      logic [RootWidth-1:0]             den;
      logic [Lanes-1:0][RootWidth-1:0]  rem;
      logic [Lanes-1:0][QuoWidth-1:0]   low;
      logic [Lanes-1:0][QuoWidth-1:0]   quo;
      logic [Lanes-1:0]                 neg;
   } div_stage_type;

endpackage

FILE: hdl/vector3_normalize_core.sv
// vector3_normalize_core: 3D vector normalization to signed Q1.14.
// Depends on v3n_pkg, v3n_sqrt_cell, v3n_div_cell.
//
// Usage:
//   req_ channel carries one vector (vec_x, vec_y, vec_z, signed 16-bit) per
//   request; rsp_ channel returns the unit vector (unit_x/y/z, Q1.14).
//   Both channels are valid/ready; a request moves when valid and ready are high.
// Pipeline, from request acceptance to rsp_valid: registers for magnitude,
//   squares and sum, 16 square-root cells (one root bit each),
//   15 divider cells (one quotient bit per lane each), one output register.
// Throughput: one request per cycle unless stalled; bubbles leave cells idle.
// Zero vector returns zeros. Quotients are clamped to +-16384.
// Reset: synchronous, active high; clears all valid bits, pipeline empties.
// Stall: when rsp_valid is high and rsp_ready low, the whole pipeline holds
//   and req_ready drops; bubbles in flight are kept, not squeezed out.
module vector3_normalize_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  v3n_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output v3n_pkg::rsp_type rsp_data
);
   import v3n_pkg::*;

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // front end: magnitudes, squares, sum
   logic [2:0]                       fv_ff;
   logic [Lanes-1:0][CompWidth-1:0]  mag_ff, mag2_ff;
   logic [Lanes-1:0]                 neg_ff, neg2_ff;
   logic [Lanes-1:0][SumWidth-1:0]   sq_ff;
   logic [Lanes-1:0][CompWidth-1:0]  mag_in;
   logic [Lanes-1:0]                 neg_in;
   logic [SumWidth-1:0]              sum_in;
   sq_stage_type                     sq_head_ff;

   always_comb begin
      neg_in[0] = req_data.vec_x[CompWidth-1];
      neg_in[1] = req_data.vec_y[CompWidth-1];
      neg_in[2] = req_data.vec_z[CompWidth-1];
      mag_in[0] = neg_in[0] ? CompWidth'(-req_data.vec_x) : req_data.vec_x;
      mag_in[1] = neg_in[1] ? CompWidth'(-req_data.vec_y) : req_data.vec_y;
      mag_in[2] = neg_in[2] ? CompWidth'(-req_data.vec_z) : req_data.vec_z;
      sum_in    = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (en) begin
         fv_ff <= {fv_ff[1:0], req_valid};
      end
      if (en) begin
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         for (int i = 0; i < Lanes; i++) begin
            sq_ff[i] <= SumWidth'(mag_ff[i]) * SumWidth'(mag_ff[i]);
         end
         mag2_ff <= mag_ff;
         neg2_ff <= neg_ff;
         sq_head_ff.n    <= sum_in;
         sq_head_ff.rem  <= '0;
         sq_head_ff.root <= '0;
         sq_head_ff.mag  <= mag2_ff;
         sq_head_ff.neg  <= neg2_ff;
      end
   end

   // square-root chain
   logic         sq_vld [RootWidth+1];
   sq_stage_type sq_st  [RootWidth+1];
   assign sq_vld[0] = fv_ff[2];
   assign sq_st[0]  = sq_head_ff;

   for (genvar k = 0; k < RootWidth; k++) begin : g_sqrt
      v3n_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (sq_vld[k]),
         .in_stage (sq_st[k]),
         .out_vld  (sq_vld[k+1]),
         .out_stage(sq_st[k+1])
      );
   end

   // divider chain: (mag << 14) / root
   logic          dv_vld [QuoWidth+1];
   div_stage_type dv_st  [QuoWidth+1];
   div_stage_type dv_head;
   always_comb begin
      dv_head.den = sq_st[RootWidth].root;
      dv_head.neg = sq_st[RootWidth].neg;
      for (int i = 0; i < Lanes; i++) begin
         dv_head.rem[i] = {1'b0, sq_st[RootWidth].mag[i][CompWidth-1:1]};
         dv_head.low[i] = {sq_st[RootWidth].mag[i][0], FracBits'(0)};
         dv_head.quo[i] = '0;
      end
   end
   assign dv_st[0]  = dv_head;
   assign dv_vld[0] = sq_vld[RootWidth];

   for (genvar k = 0; k < QuoWidth; k++) begin : g_div
      v3n_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (dv_vld[k]),
         .in_stage (dv_st[k]),
         .out_vld  (dv_vld[k+1]),
         .out_stage(dv_st[k+1])
      );
   end

   // output register: clamp, sign, zero vector
   logic                            out_vld_ff;
   rsp_type                         out_ff;
   logic [Lanes-1:0][CompWidth-1:0] res;
   logic [QuoWidth-1:0]             q;

   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         q = (dv_st[QuoWidth].quo[i] > QOne) ? QOne : dv_st[QuoWidth].quo[i];
         if (dv_st[QuoWidth].den == '0) begin
            res[i] = '0;
         end else if (dv_st[QuoWidth].neg[i]) begin
            res[i] = CompWidth'(-{1'b0, q});
         end else begin
            res[i] = {1'b0, q};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= dv_vld[QuoWidth];
      end
      if (en) begin
         out_ff.unit_x <= res[0];
         out_ff.unit_y <= res[1];
         out_ff.unit_z <= res[2];
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;
endmodule

FILE: hdl/v3n_sqrt_cell.sv
// v3n_sqrt_cell: one result bit of the integer square root, registered.
// Depends on v3n_pkg.
module v3n_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  v3n_pkg::sq_stage_type in_stage,
   output logic                  out_vld,
   output v3n_pkg::sq_stage_type out_stage
);
   import v3n_pkg::*;

   logic                  vld_ff;
   sq_stage_type          stage_ff, stage_in;
   logic [RootWidth+2:0]  rem_new;
   logic [RootWidth+2:0]  trial;
   logic [RootWidth+2:0]  diff;
   logic                  ge;

   always_comb begin
      rem_new = {in_stage.rem[RootWidth:0], in_stage.n[SumWidth-1 -: 2]};
      trial   = {1'b0, in_stage.root, 2'b01};
      diff    = rem_new - trial;
      ge      = (rem_new >= trial);
      stage_in      = in_stage;
      stage_in.n    = {in_stage.n[SumWidth-3:0], 2'b00};
      stage_in.rem  = ge ? diff[RootWidth+1:0] : rem_new[RootWidth+1:0];
      stage_in.root = {in_stage.root[RootWidth-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_vld   = vld_ff;
   assign out_stage = stage_ff;
endmodule

FILE: hdl/v3n_div_cell.sv
// v3n_div_cell: one quotient bit for each of the three lanes, registered.
// Depends on v3n_pkg.
module v3n_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  v3n_pkg::div_stage_type in_stage,
   output logic                   out_vld,
   output v3n_pkg::div_stage_type out_stage
);
   import v3n_pkg::*;

   logic                  vld_ff;
   div_stage_type         stage_ff, stage_in;
   logic [RootWidth:0]    rn [Lanes];
   logic [RootWidth:0]    diff [Lanes];
   logic [Lanes-1:0]      ge;

   always_comb begin
      stage_in = in_stage;
      for (int i = 0; i < Lanes; i++) begin
         rn[i]   = {in_stage.rem[i], in_stage.low[i][QuoWidth-1]};
         diff[i] = rn[i] - {1'b0, in_stage.den};
         ge[i]   = (rn[i] >= {1'b0, in_stage.den});
         stage_in.rem[i] = ge[i] ? diff[i][RootWidth-1:0] : rn[i][RootWidth-1:0];
         stage_in.low[i] = {in_stage.low[i][QuoWidth-2:0], 1'b0};
         stage_in.quo[i] = {in_stage.quo[i][QuoWidth-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_vld   = vld_ff;
   assign out_stage = stage_ff;
endmodule

FILE: hdl/v3n_checker.sv
// v3n_checker: port-level assertions for vector3_normalize_core, with bind.
// Depends on v3n_pkg.
module v3n_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input v3n_pkg::rsp_type rsp_data
);
   import v3n_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.unit_x >= -16'sd16384 && rsp_data.unit_x <= 16'sd16384 &&
                    rsp_data.unit_y >= -16'sd16384 && rsp_data.unit_y <= 16'sd16384 &&
                    rsp_data.unit_z >= -16'sd16384 && rsp_data.unit_z <= 16'sd16384)
      else $error("unit component out of range");
endmodule

bind vector3_normalize_core v3n_checker u_v3n_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
